/* src/int_to_decimal_ascii_top_defines.svh */
// assertion macros for the integer to decimal text converter
`ifndef INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// same-cycle implication
`define ITOA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itoa check failed");

// next-cycle implication
`define ITOA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itoa check failed");

`endif

/* src/itoa_pkg.sv */
// shared constants and helpers for the integer to decimal text converter
`default_nettype none

package itoa_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'd48;
    localparam logic [7:0] CHAR_MINUS = 8'd45;

    localparam int CHAR_BITS = 8;

    // upper bound on decimal digits of a magnitude of the given width
    function automatic int dec_digits(input int bits);
        return ((bits * 1233) >> 12) + 1;
    endfunction

endpackage

`default_nettype wire

/* src/int_to_decimal_ascii_top.sv */
// Signed integer to decimal ASCII text converter, bit-serial double-dabble
// core. One request carries a VALUE_BITS two's complement integer; the block
// answers with its decimal text, most significant character first, a '-' in
// front of negative values, leading zeros suppressed, tlast on the final
// character. A request shifts its VALUE_BITS magnitude bits through the BCD shift
// register, then steps through every decimal digit slot (10 at 32 bits, skipped
// leading zeros included), with the '-' emitted ahead of the digits. A new request
// is taken once the last character sits in the output register.
`default_nettype none
`include "int_to_decimal_ascii_top_defines.svh"

module int_to_decimal_ascii_top #(
    parameter int VALUE_BITS = itoa_pkg::VALUE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // value
    input  wire logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // char_code
    output logic [itoa_pkg::CHAR_BITS-1:0]           m_axis_tdata,
    // last_char
    output logic                                     m_axis_tlast
);

    localparam int NDIG = itoa_pkg::dec_digits(VALUE_BITS);
    localparam int BCDW = NDIG * 4;
    localparam int BCW  = $clog2(VALUE_BITS + 1);
    localparam int DCW  = $clog2(NDIG + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCDW-1:0]       bcd_reg, bcd_next;
    logic [BCW-1:0]        bit_cnt_reg, bit_cnt_next;
    logic [DCW-1:0]        dig_cnt_reg, dig_cnt_next;
    logic                  neg_reg, neg_next;
    logic                  started_reg, started_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_last_reg, out_last_next;

    logic [VALUE_BITS-1:0] raw;
    logic [BCDW-1:0]       bcd_adj;
    logic [3:0]            top_dig;
    logic                  out_free;
    logic                  in_acc;

    assign raw      = s_axis_tdata[VALUE_BITS-1:0];
    assign top_dig  = bcd_reg[BCDW-1 -: 4];
    assign out_free = !out_valid_reg || m_axis_tready;
    assign in_acc   = s_axis_tvalid && s_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    // add 3 to every digit of 5 or more ahead of the shift
    always_comb
    begin
        logic [3:0] d;
        bcd_adj = '0;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? (d + 4'd3) : d;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        bit_cnt_next   = bit_cnt_reg;
        dig_cnt_next   = dig_cnt_reg;
        neg_next       = neg_reg;
        started_next   = started_reg;
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    neg_next     = raw[VALUE_BITS-1];
                    mag_next     = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
                    bcd_next     = '0;
                    bit_cnt_next = BCW'(VALUE_BITS);
                    started_next = 1'b0;
                    state_next   = ST_CONV;
                end
            end
            ST_CONV:
            begin
                bcd_next     = {bcd_adj[BCDW-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == BCW'(1))
                begin
                    dig_cnt_next = DCW'(NDIG);
                    state_next   = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::CHAR_MINUS;
                    out_last_next  = 1'b0;
                    state_next     = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // leading zero: drop the digit without output
                if (!started_reg && top_dig == 4'd0 && dig_cnt_reg > DCW'(1))
                begin
                    bcd_next     = {bcd_reg[BCDW-5:0], 4'd0};
                    dig_cnt_next = dig_cnt_reg - 1'b1;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = itoa_pkg::CHAR_ZERO + {4'd0, top_dig};
                    out_last_next  = (dig_cnt_reg == DCW'(1));
                    started_next   = 1'b1;
                    bcd_next       = {bcd_reg[BCDW-5:0], 4'd0};
                    dig_cnt_next   = dig_cnt_reg - 1'b1;
                    if (dig_cnt_reg == DCW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            started_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
            dig_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            started_reg   <= started_next;
            bit_cnt_reg   <= bit_cnt_next;
            dig_cnt_reg   <= dig_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        neg_reg      <= neg_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    `ITOA_ASSERT_NEXT(a_accept_starts_conv, clk, rst_n, in_acc, (state_reg == ST_CONV) && (bit_cnt_reg == BCW'(VALUE_BITS)))
    `ITOA_ASSERT_NOW(a_emit_has_digits, clk, rst_n, state_reg == ST_EMIT, dig_cnt_reg != '0)
    `ITOA_ASSERT_NOW(a_minus_not_last, clk, rst_n, m_axis_tvalid && (m_axis_tdata == itoa_pkg::CHAR_MINUS), !m_axis_tlast)

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// testbench for the integer to decimal text converter
`timescale 1ns / 100ps

module tb_top;

    localparam int VALUE_BITS = 32;
    localparam int DATA_BITS = ((VALUE_BITS + 7) / 8) * 8;
    localparam int RADIX = 10;
    localparam int RANDOM_ITEMS = 300;
    localparam int CALM_ITEMS = 50;
    localparam int DRAIN_CYCLES = 60;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } text_char_t;

    class decimal_text_checker;
        text_char_t pending_chars[$];
        int         mismatches;

        function new();
            mismatches = 0;
        endfunction

        // predicted decimal text of one accepted request
        function void note_value(logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] mag;
            logic [7:0]            digits[$];
            text_char_t            ch;
            mag = value[VALUE_BITS-1] ? (~value + 1'b1) : value;
            do
            begin
                digits.push_front(itoa_pkg::CHAR_ZERO + 8'(mag % RADIX));
                mag = mag / RADIX;
            end
            while (mag != 0);
            if (value[VALUE_BITS-1])
            begin
                ch.code = itoa_pkg::CHAR_MINUS;
                ch.last = 1'b0;
                pending_chars.push_back(ch);
            end
            foreach (digits[i])
            begin
                ch.code = digits[i];
                ch.last = (i == digits.size() - 1);
                pending_chars.push_back(ch);
            end
        endfunction

        function void check_char(logic [7:0] code, logic last);
            text_char_t want;
            if (pending_chars.size() == 0)
            begin
                $error("unexpected character: code %0d last %0d", code, last);
                mismatches++;
                return;
            end
            want = pending_chars.pop_front();
            if (code !== want.code)
            begin
                $error("char_code mismatch: expected %0d actual %0d", want.code, code);
                mismatches++;
            end
            if (last !== want.last)
            begin
                $error("last_char mismatch: expected %0d actual %0d", want.last, last);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_chars.size();
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [DATA_BITS-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [7:0]           m_axis_tdata;
    logic                 m_axis_tlast;

    decimal_text_checker text_sb = new();
    bit                  calm = 1'b0;
    longint              cycles = 0;

    int_to_decimal_ascii_top #(
        .VALUE_BITS(VALUE_BITS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            text_sb.check_char(m_axis_tdata, m_axis_tlast);
    end

    // output side stalls, with quiet stretches in between
    initial
    begin
        int burst;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (calm || $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(30, 120)) @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 11);
                m_axis_tready <= 1'b0;
                repeat (burst) @(posedge clk);
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end
        end
    end

    task automatic send_value(input logic [VALUE_BITS-1:0] value);
        s_axis_tdata <= DATA_BITS'(value);
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        text_sb.note_value(value);
    endtask

    task automatic input_gap();
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
    endtask

    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (text_sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [VALUE_BITS-1:0] random_value();
        logic [VALUE_BITS-1:0] v;
        logic [VALUE_BITS-1:0] p;
        int                    n;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = $urandom >> $urandom_range(0, VALUE_BITS - 1);
            default:
            begin
                // around a power of ten
                p = 1;
                n = $urandom_range(0, 9);
                repeat (n) p = p * RADIX;
                v = p + $urandom_range(0, 2) - 1;
            end
        endcase
        if ($urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    initial
    begin
        logic [VALUE_BITS-1:0] directed[$];
        int                    i;
        directed = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            -32'sd100, 32'd2147483647, 32'h80000000, -32'sd2147483647,
            32'd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
            -32'sd1234567890, 32'd7, -32'sd5, 32'd1000000001, 32'hFFFFFFFE,
            32'h55555555, 32'hAAAAAAAA
        };
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[k])
        begin
            input_gap();
            send_value(directed[k]);
        end
        hold_until_drained();
        repeat ($urandom_range(1, 50)) @(posedge clk);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                hold_until_drained();
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                calm = 1'b1;
            input_gap();
            send_value(random_value());
        end
        s_axis_tvalid <= 1'b0;

        while (text_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (text_sb.mismatches == 0 && text_sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/itoa_pkg.sv
src/int_to_decimal_ascii_top.sv
tb/tb_top.sv
